>>> rtl/dits_pkg.sv
// Shared types and constants of the depth image to scan block.
`default_nettype none

package dits_pkg;

	localparam int unsigned MAX_COLUMNS_DEF = 1024;

	// result queue between the arithmetic pipeline and the output channel
	localparam int unsigned OUTQ_DEPTH = 32;
	localparam int unsigned OUTQ_AW    = 5;

	// quotient bits below the saturation point of the lateral offset
	localparam int unsigned QUO_BITS = 15;
	localparam logic [15:0] LATERAL_LIMIT = 16'd32767;

	localparam int unsigned DIV_W = 34;

	typedef enum logic [2:0] {
		CFG_FOCAL_X   = 3'd0,
		CFG_FOCAL_Y   = 3'd1,
		CFG_CENTER_X  = 3'd2,
		CFG_CENTER_Y  = 3'd3,
		CFG_BAND_LOW  = 3'd4,
		CFG_BAND_HIGH = 3'd5,
		CFG_MIN_RANGE = 3'd6
	} cfg_idx_t;

	// pixel request as it enters the column store
	typedef struct packed {
		logic [15:0]        depth;
		logic [9:0]         column;
		logic               row0;
		logic               last;
		logic               gt_min;
		logic signed [34:0] num;
		logic [15:0]        aoff;
		logic               opos;
	} pix_t;

	// completed column handed to the lateral unit
	typedef struct packed {
		logic [9:0]  column;
		logic [15:0] range;
		logic [15:0] aoff;
		logic        opos;
	} scan_req_t;

	// sideband carried along the divider stages
	typedef struct packed {
		logic [9:0]  column;
		logic [15:0] range;
		logic        neg;
		logic        zero;
		logic        sat;
	} div_tag_t;

	typedef struct packed {
		logic [9:0]  column;
		logic [15:0] range;
		logic [15:0] lateral;
		logic        hit;
	} scan_res_t;

endpackage

`default_nettype wire

>>> rtl/depth_image_to_scan.sv
// Depth image to scan: top level with configuration, pixel front end and credit control.
// A last-row pixel's request passes the column store, divider and output queue.
// Throughput: one pixel per cycle while pix_stall is low; the column store does one
// read and one write per cycle and the lateral divider is pipelined one quotient bit
// per stage. The pixel side stalls only while 32 scan requests are pending downstream.
// Reset clears control state and loads register defaults; the column store is
// not cleared and holds garbage until row 0 of a frame writes each column.
`default_nettype none

module depth_image_to_scan #(
	parameter int unsigned MAX_COLUMNS = dits_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        pix_valid,
	output logic             pix_stall,
	input  wire logic [15:0] pix_depth,
	input  wire logic [9:0]  column,
	input  wire logic [9:0]  row,
	input  wire logic        last_row,

	output logic             scan_valid,
	input  wire logic        scan_stall,
	output logic [9:0]       out_column,
	output logic [15:0]      range_mm,
	output logic [15:0]      lateral_mm,
	output logic             hit,

	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [15:0] wr_data
);

	localparam int unsigned AW = $clog2(MAX_COLUMNS);
	localparam int unsigned PW = dits_pkg::OUTQ_AW + 1;

	// configuration registers
	logic [15:0]        focal_x_q;
	logic [15:0]        focal_y_q;
	logic [15:0]        center_x_q;
	logic [15:0]        center_y_q;
	logic signed [15:0] band_low_q;
	logic signed [15:0] band_high_q;
	logic [15:0]        min_range_q;

	// height band bounds scaled by focal_y, refreshed every cycle
	logic signed [32:0] lo_q;
	logic signed [32:0] hi_q;
	logic signed [34:0] lo_ext;
	logic signed [34:0] hi_ext;

	logic [PW-1:0] pend_q;

	logic               accept;
	logic [12:0]        col13;
	logic               in_range;
	logic               store_acc;
	logic [AW-1:0]      addr;
	logic signed [17:0] rterm;
	logic signed [17:0] off;
	logic [17:0]        off_abs;
	dits_pkg::pix_t     pix;

	logic                req_valid;
	dits_pkg::scan_req_t req;
	logic                res_valid;
	dits_pkg::scan_res_t res;
	dits_pkg::scan_res_t head;
	logic                pop;
	logic                inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q   <= 16'd8400;
			focal_y_q   <= 16'd8400;
			center_x_q  <= 16'd5120;
			center_y_q  <= 16'd3840;
			band_low_q  <= -16'sd300;
			band_high_q <= 16'sd100;
			min_range_q <= 16'd50;
		end else if (wr_en) begin
			case (dits_pkg::cfg_idx_t'(wr_index))
				dits_pkg::CFG_FOCAL_X:   focal_x_q   <= wr_data;
				dits_pkg::CFG_FOCAL_Y:   focal_y_q   <= wr_data;
				dits_pkg::CFG_CENTER_X:  center_x_q  <= wr_data;
				dits_pkg::CFG_CENTER_Y:  center_y_q  <= wr_data;
				dits_pkg::CFG_BAND_LOW:  band_low_q  <= $signed(wr_data);
				dits_pkg::CFG_BAND_HIGH: band_high_q <= $signed(wr_data);
				dits_pkg::CFG_MIN_RANGE: min_range_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Precompute band * focal_y so the pixel path only compares cross products.
	always_ff @(posedge clk) begin
		lo_q <= $signed({{17{band_low_q[15]}}, band_low_q}) * $signed({17'd0, focal_y_q});
		hi_q <= $signed({{17{band_high_q[15]}}, band_high_q}) * $signed({17'd0, focal_y_q});
	end

	assign lo_ext = $signed({{2{lo_q[32]}}, lo_q});
	assign hi_ext = $signed({{2{hi_q[32]}}, hi_q});

	// Accept while fewer than a full queue of scan requests are pending.
	assign pix_stall = (pend_q == PW'(dits_pkg::OUTQ_DEPTH));
	assign accept    = pix_valid && !pix_stall;

	// Drop columns beyond the store: no update and no scan request.
	assign col13     = {3'd0, column};
	assign in_range  = (col13 < 13'(MAX_COLUMNS));
	assign store_acc = accept && in_range;
	assign addr      = col13[AW-1:0];

	// Front end: row and column offsets in 1/16 pixel, then the height product.
	always_comb begin
		rterm   = $signed({4'd0, row, 4'd0}) - $signed({2'd0, center_y_q});
		off     = $signed({4'd0, column, 4'd0}) - $signed({2'd0, center_x_q});
		off_abs = off[17] ? (18'd0 - off) : off;

		pix.depth  = pix_depth;
		pix.column = column;
		pix.row0   = (row == 10'd0);
		pix.last   = last_row;
		pix.gt_min = (pix_depth > min_range_q);
		pix.num    = $signed({{17{rterm[17]}}, rterm}) * $signed({19'd0, pix_depth});
		pix.aoff   = off_abs[15:0];
		// the scan axis points left, so a column right of center gives a negative lateral
		pix.opos   = !off[17] && (off != 18'sd0);
	end

	dits_colmin #(
		.DEPTH (MAX_COLUMNS),
		.AW    (AW)
	) u_colmin (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (store_acc),
		.addr      (addr),
		.pix       (pix),
		.lo        (lo_ext),
		.hi        (hi_ext),
		.req_valid (req_valid),
		.req       (req)
	);

	dits_lateral u_lateral (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.focal_x   (focal_x_q),
		.res_valid (res_valid),
		.res       (res)
	);

	assign pop = scan_valid && !scan_stall;

	dits_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.din       (res),
		.pop       (pop),
		.not_empty (scan_valid),
		.dout      (head)
	);

	assign out_column = head.column;
	assign range_mm   = head.range;
	assign lateral_mm = head.lateral;
	assign hit        = head.hit;

	// Count each scan request from acceptance until it leaves the output.
	assign inc = store_acc && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (inc && !pop)
			pend_q <= pend_q + 1'b1;
		else if (pop && !inc)
			pend_q <= pend_q - 1'b1;
	end

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(dits_pkg::OUTQ_DEPTH))
		else $error("pending scan count exceeds queue depth");

	a_valid_pending: assert property (@(posedge clk) disable iff (!arst_n)
		scan_valid |-> (pend_q != '0))
		else $error("scan request shown with nothing pending");

	a_pend_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(inc && !pop) |=> (pend_q == $past(pend_q) + 1'b1))
		else $error("pending count missed an accepted last-row pixel");

	a_no_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_valid && !hit) |-> ((range_mm == 16'd0) && (lateral_mm == 16'd0)))
		else $error("column without hit reports nonzero range or lateral");

endmodule

`default_nettype wire

>>> rtl/dits_colmin.sv
// Per-column nearest range store: read, update and write back with forwarding.
`default_nettype none

module dits_colmin #(
	parameter int unsigned DEPTH = dits_pkg::MAX_COLUMNS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               acc,
	input  wire logic [AW-1:0]      addr,
	input  wire dits_pkg::pix_t     pix,
	input  wire logic signed [34:0] lo,
	input  wire logic signed [34:0] hi,
	output logic                    req_valid,
	output dits_pkg::scan_req_t     req
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rd_q;

	logic           vld_s1;
	dits_pkg::pix_t pix_s1;
	logic [AW-1:0]  addr_s1;

	logic          wr_vld_q;
	logic [AW-1:0] wr_addr_q;
	logic [15:0]   wr_val_q;

	logic                req_vld_s2;
	dits_pkg::scan_req_t req_s2;

	logic        ok;
	logic [15:0] old;
	logic [15:0] cur;

	always_ff @(posedge clk) begin
		if (vld_s1)
			mem[addr_s1] <= cur;
		if (acc)
			rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			wr_vld_q   <= 1'b0;
			req_vld_s2 <= 1'b0;
		end else begin
			vld_s1     <= acc;
			wr_vld_q   <= vld_s1;
			req_vld_s2 <= vld_s1 & pix_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pix;
			addr_s1 <= addr;
		end
		wr_addr_q     <= addr_s1;
		wr_val_q      <= cur;
		req_s2.column <= pix_s1.column;
		req_s2.range  <= cur;
		req_s2.aoff   <= pix_s1.aoff;
		req_s2.opos   <= pix_s1.opos;
	end

	always_comb begin
		ok = pix_s1.gt_min && ($signed(pix_s1.num) >= lo) && ($signed(pix_s1.num) < hi);
		// take the value written at the edge this read was issued
		old = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_val_q : rd_q;
		if (pix_s1.row0)
			cur = ok ? pix_s1.depth : 16'd0;
		else if (ok && ((old == 16'd0) || (pix_s1.depth < old)))
			cur = pix_s1.depth;
		else
			cur = old;
	end

	assign req_valid = req_vld_s2;
	assign req       = req_s2;

endmodule

`default_nettype wire

>>> rtl/dits_lateral.sv
// Lateral offset: product, rounding bias and a pipelined restoring divider.
`default_nettype none

module dits_lateral (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire dits_pkg::scan_req_t req,
	input  wire logic [15:0]         focal_x,
	output logic                     res_valid,
	output dits_pkg::scan_res_t      res
);

	localparam int unsigned QB = dits_pkg::QUO_BITS;
	localparam int unsigned DW = dits_pkg::DIV_W;

	logic               vld_s3;
	logic [31:0]        mag_s3;
	dits_pkg::div_tag_t tag_s3;

	logic               vld_s4;
	logic [DW-1:0]      num_s4;
	dits_pkg::div_tag_t tag_s4;

	logic               dvld_q [QB+1];
	logic [DW-1:0]      rem_q  [QB+1];
	logic [QB-1:0]      quo_q  [QB+1];
	dits_pkg::div_tag_t dtag_q [QB+1];

	logic                res_vld_q;
	dits_pkg::scan_res_t res_q;

	logic [DW-1:0] den;
	logic [DW-1:0] den_top;
	logic [15:0]   qmag;
	logic [15:0]   lat;

	assign den     = {17'd0, focal_x, 1'b0};
	assign den_top = den << QB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			dvld_q[0] <= 1'b0;
		end else begin
			vld_s3    <= req_valid;
			vld_s4    <= vld_s3;
			dvld_q[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		mag_s3        <= {16'd0, req.aoff} * {16'd0, req.range};
		tag_s3.column <= req.column;
		tag_s3.range  <= req.range;
		tag_s3.neg    <= req.opos;
		tag_s3.zero   <= 1'b0;
		tag_s3.sat    <= 1'b0;

		// round half up: (2*mag + f) / (2*f)
		num_s4        <= {1'b0, mag_s3, 1'b0} + {18'd0, focal_x};
		tag_s4.column <= tag_s3.column;
		tag_s4.range  <= tag_s3.range;
		tag_s4.neg    <= tag_s3.neg;
		tag_s4.zero   <= (mag_s3 == 32'd0);
		tag_s4.sat    <= tag_s3.sat;

		// saturate when the quotient reaches the top bit
		rem_q[0]         <= num_s4;
		quo_q[0]         <= '0;
		dtag_q[0].column <= tag_s4.column;
		dtag_q[0].range  <= tag_s4.range;
		dtag_q[0].neg    <= tag_s4.neg;
		dtag_q[0].zero   <= tag_s4.zero;
		dtag_q[0].sat    <= (num_s4 >= den_top);
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int unsigned B = QB - 1 - k;
		logic [DW-1:0] dsh;
		logic          trial;

		assign dsh   = den << B;
		assign trial = (rem_q[k] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dvld_q[k+1] <= 1'b0;
			else
				dvld_q[k+1] <= dvld_q[k];
		end

		always_ff @(posedge clk) begin
			rem_q[k+1]  <= trial ? (rem_q[k] - dsh) : rem_q[k];
			quo_q[k+1]  <= {quo_q[k][QB-2:0], trial};
			dtag_q[k+1] <= dtag_q[k];
		end
	end

	always_comb begin
		qmag = dtag_q[QB].sat ? dits_pkg::LATERAL_LIMIT : {1'b0, quo_q[QB]};
		if (dtag_q[QB].zero)
			lat = 16'd0;
		else if (dtag_q[QB].neg)
			lat = 16'd0 - qmag;
		else
			lat = qmag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_q <= 1'b0;
		else
			res_vld_q <= dvld_q[QB];
	end

	always_ff @(posedge clk) begin
		res_q.column  <= dtag_q[QB].column;
		res_q.range   <= dtag_q[QB].range;
		res_q.lateral <= lat;
		res_q.hit     <= (dtag_q[QB].range != 16'd0);
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

endmodule

`default_nettype wire

>>> rtl/dits_outq.sv
// Result queue in front of the scan output channel.
`default_nettype none

module dits_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire dits_pkg::scan_res_t din,
	input  wire logic                pop,
	output logic                     not_empty,
	output dits_pkg::scan_res_t      dout
);

	localparam int unsigned AW = dits_pkg::OUTQ_AW;

	dits_pkg::scan_res_t store_q [dits_pkg::OUTQ_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign not_empty = (cnt_q != '0);
	assign dout      = store_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the depth image to scan block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Allow for the pipeline to drain, plus margin, before a register write or the end.
	localparam int DRAIN_CYCLES = 40;
	// Length of the long receiver hold-off that forces the block to stall its input.
	localparam int HOLD_CYCLES  = 400;
	localparam int LIMIT_CYCLES = 300000;
	localparam int NUM_COLUMNS  = 1024;

	typedef struct packed {
		logic [15:0] depth;
		logic [9:0]  column;
		logic [9:0]  row;
		logic        last_row;
	} pixel_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;

	logic        pix_valid = 1'b0;
	logic        pix_stall;
	pixel_t      drive_px  = '0;
	logic [15:0] pix_depth;
	logic [9:0]  column;
	logic [9:0]  row;
	logic        last_row;

	logic        scan_valid;
	logic        scan_stall = 1'b0;
	logic [9:0]  out_column;
	logic [15:0] range_mm;
	logic [15:0] lateral_mm;
	logic        hit;

	logic        wr_en    = 1'b0;
	logic [2:0]  wr_index = '0;
	logic [15:0] wr_data  = '0;

	// Camera registers as the block should currently hold them.
	logic [15:0]        cam_focal_x   = 16'd8400;
	logic [15:0]        cam_focal_y   = 16'd8400;
	logic [15:0]        cam_center_x  = 16'd5120;
	logic [15:0]        cam_center_y  = 16'd3840;
	logic signed [15:0] cam_band_low  = -16'sd300;
	logic signed [15:0] cam_band_high = 16'sd100;
	logic [15:0]        cam_min_range = 16'd50;

	// Nearest qualifying depth per column, 0 when the column has no hit.
	logic [15:0] column_nearest [NUM_COLUMNS];
	// Columns that a row-0 pixel has already written; only these may see later rows.
	bit          column_seeded  [NUM_COLUMNS];

	pixel_t              pixel_queue[$];
	dits_pkg::scan_res_t pending_scans[$];

	int          queued_pixels = 0;
	int          mismatches    = 0;
	int          cycle_count   = 0;
	bit          pix_taken     = 1'b0;

	int          burst_left = 0;
	int          gap_left   = 0;

	stall_mode_t stall_mode   = STALL_NONE;
	int          mode_left    = 0;
	int          hold_left    = 0;
	bit          hold_off_req = 1'b0;

	assign pix_depth = drive_px.depth;
	assign column    = drive_px.column;
	assign row       = drive_px.row;
	assign last_row  = drive_px.last_row;

	depth_image_to_scan dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix_depth  (pix_depth),
		.column     (column),
		.row        (row),
		.last_row   (last_row),
		.scan_valid (scan_valid),
		.scan_stall (scan_stall),
		.out_column (out_column),
		.range_mm   (range_mm),
		.lateral_mm (lateral_mm),
		.hit        (hit),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	always #6ns clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Height test without division: compare (16*row - cy) * z against the band
	// edges scaled by the vertical focal length.
	function automatic bit in_height_band(logic [15:0] z, logic [9:0] r);
		longint num, lo, hi;
		if (z <= cam_min_range)
			return 1'b0;
		num = (longint'(r) * 16 - longint'(cam_center_y)) * longint'(z);
		lo  = longint'(cam_band_low) * longint'(cam_focal_y);
		hi  = longint'(cam_band_high) * longint'(cam_focal_y);
		return (num >= lo) && (num < hi);
	endfunction

	// Negated horizontal offset, rounded half away from zero, saturated.
	function automatic logic [15:0] lateral_offset(logic [9:0] col, logic [15:0] rng);
		longint p, mag, q;
		p   = -((longint'(col) * 16 - longint'(cam_center_x)) * longint'(rng));
		mag = (p < 0) ? -p : p;
		if (mag == 0)
			return 16'd0;
		if (cam_focal_x == 0) begin
			q = longint'(dits_pkg::LATERAL_LIMIT);
		end else begin
			q = (mag * 2 + longint'(cam_focal_x)) / (2 * longint'(cam_focal_x));
			if (q > longint'(dits_pkg::LATERAL_LIMIT))
				q = longint'(dits_pkg::LATERAL_LIMIT);
		end
		return (p < 0) ? 16'(-q) : 16'(q);
	endfunction

	// Fold one pixel into its column; return 1 with the scan when the pixel
	// completes the column.
	function automatic bit column_scan(input pixel_t px, output dits_pkg::scan_res_t res);
		logic [15:0] near;
		bit          ok;
		ok   = in_height_band(px.depth, px.row);
		near = column_nearest[px.column];
		if (px.row == 0)
			near = ok ? px.depth : 16'd0;
		else if (ok && (near == 0 || px.depth < near))
			near = px.depth;
		column_nearest[px.column] = near;
		res.column  = px.column;
		res.range   = near;
		res.hit     = (near != 0);
		res.lateral = (near != 0) ? lateral_offset(px.column, near) : 16'd0;
		return px.last_row;
	endfunction

	// ------------------------------------------------------------------
	// Pixel side: driver and acceptance monitor
	// ------------------------------------------------------------------

	// Predict at the edge where the request is taken; the payload is stable here.
	always @(posedge clk) begin
		dits_pkg::scan_res_t res;
		if (arst_n && pix_valid && !pix_stall) begin
			if (column_scan(drive_px, res))
				pending_scans.insert(pending_scans.size(), res);
			pix_taken = 1'b1;
		end
	end

	// Hold a stalled request; otherwise advance to the next one, in bursts
	// separated by random gaps. Valid never looks at the stall.
	always @(negedge clk) begin
		logic   next_valid;
		pixel_t next_px;
		next_valid = pix_valid;
		next_px    = drive_px;
		if (!pix_valid || pix_taken) begin
			pix_taken  = 1'b0;
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pixel_queue.size() > 0) begin
				next_px    = pixel_queue.pop_front();
				next_valid = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					// a third of the bursts run straight into the next one
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
		pix_valid <= next_valid;
		drive_px  <= next_px;
	end

	// ------------------------------------------------------------------
	// Scan side: stall pattern and result checker
	// ------------------------------------------------------------------

	// Switch among stall patterns every so often; a hold-off request overrides
	// the pattern and holds the stall until its countdown here runs out.
	always @(negedge clk) begin
		logic stall_next;
		if (hold_off_req) begin
			hold_off_req = 1'b0;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall_next = 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(16, 160);
			end
			mode_left--;
			case (stall_mode)
			STALL_NONE:  stall_next = 1'b0;
			STALL_COIN:  stall_next = 1'($urandom_range(0, 1));
			STALL_HEAVY: stall_next = ($urandom_range(0, 7) != 0);
			default:     stall_next = (mode_left % 8) < 3;
			endcase
		end
		scan_stall <= stall_next;
	end

	always @(posedge clk) begin
		dits_pkg::scan_res_t want;
		if (arst_n && scan_valid && !scan_stall) begin
			if (pending_scans.size() == 0) begin
				$error("unexpected scan request for column %0d", out_column);
				mismatches++;
			end else begin
				want = pending_scans.pop_front();
				if (out_column !== want.column) begin
					$error("out_column: expected %0d, got %0d", want.column, out_column);
					mismatches++;
				end
				if (range_mm !== want.range) begin
					$error("range_mm: expected %0d, got %0d", want.range, range_mm);
					mismatches++;
				end
				if (lateral_mm !== want.lateral) begin
					$error("lateral_mm: expected %0d, got %0d",
						$signed(want.lateral), $signed(lateral_mm));
					mismatches++;
				end
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a hang anywhere ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic push_pixel(int z, int col, int r, bit last);
		pixel_t px;
		px = '{depth: 16'(z), column: 10'(col), row: 10'(r), last_row: last};
		pixel_queue.insert(pixel_queue.size(), px);
		if (r == 0)
			column_seeded[col] = 1'b1;
		queued_pixels++;
	endtask

	// Mostly depths in the working range, with no-measurement pixels, the
	// full 16-bit span, and values right at the minimum range.
	function automatic int random_depth();
		int z;
		case ($urandom_range(0, 9))
		0:       z = 0;
		1, 2:    z = $urandom_range(0, 65535);
		3:       z = int'(cam_min_range) + $urandom_range(0, 2);
		default: z = $urandom_range(1, 6000);
		endcase
		return (z > 65535) ? 65535 : z;
	endfunction

	// One well-formed frame: a block of columns, row 0 first, later rows
	// clustered around the optical center so that the band test matters.
	task automatic push_frame();
		int width, height, first_col, base, spread, r, h, c;
		width     = $urandom_range(1, 12);
		height    = $urandom_range(1, 6);
		first_col = $urandom_range(0, NUM_COLUMNS - width);
		base      = cam_center_y / 16;
		if (base < 1)
			base = 1;
		if (base > 1023)
			base = 1023;
		spread = $urandom_range(2, 40);
		for (h = 0; h < height; h++) begin
			if (h == 0) begin
				r = 0;
			end else if ($urandom_range(0, 9) == 0) begin
				r = $urandom_range(1, 1023);
			end else begin
				r = base + $urandom_range(0, 2 * spread) - spread;
				if (r < 1)
					r = 1;
				if (r > 1023)
					r = 1023;
			end
			for (c = 0; c < width; c++)
				push_pixel(random_depth(), first_col + c, r, h == height - 1);
		end
	endtask

	// Loose pixels outside any frame; later rows only hit written columns.
	task automatic push_noise(int n);
		int k, col, r;
		for (k = 0; k < n; k++) begin
			col = $urandom_range(0, NUM_COLUMNS - 1);
			if (column_seeded[col] && $urandom_range(0, 3) != 0)
				r = $urandom_range(1, 1023);
			else
				r = 0;
			push_pixel(random_depth(), col, r, $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic push_random(int n);
		int goal;
		goal = queued_pixels + n;
		while (queued_pixels < goal) begin
			if ($urandom_range(0, 4) != 0)
				push_frame();
			else
				push_noise($urandom_range(1, 4));
		end
	endtask

	// Wait until every queued request went in and every scan came back.
	task automatic wait_drained();
		while (pixel_queue.size() != 0 || pix_valid || pending_scans.size() != 0)
			@(negedge clk);
	endtask

	// Pixels that produce no scan may still be in flight after the last scan.
	task automatic settle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write all seven registers, one per cycle; call only while idle.
	task automatic program_camera(int fx, int fy, int cx, int cy, int lo, int hi, int minr);
		dits_pkg::cfg_idx_t idx;
		logic [15:0]        val;
		idx = idx.first();
		do begin
			case (idx)
			dits_pkg::CFG_FOCAL_X:   val = 16'(fx);
			dits_pkg::CFG_FOCAL_Y:   val = 16'(fy);
			dits_pkg::CFG_CENTER_X:  val = 16'(cx);
			dits_pkg::CFG_CENTER_Y:  val = 16'(cy);
			dits_pkg::CFG_BAND_LOW:  val = 16'(lo);
			dits_pkg::CFG_BAND_HIGH: val = 16'(hi);
			default:                 val = 16'(minr);
			endcase
			@(negedge clk);
			wr_en    <= 1'b1;
			wr_index <= idx;
			wr_data  <= val;
			idx = idx.next();
		end while (idx != idx.first());
		@(negedge clk);
		wr_en <= 1'b0;
		cam_focal_x   = 16'(fx);
		cam_focal_y   = 16'(fy);
		cam_center_x  = 16'(cx);
		cam_center_y  = 16'(cy);
		cam_band_low  = 16'(lo);
		cam_band_high = 16'(hi);
		cam_min_range = 16'(minr);
	endtask

	// A plausible camera with a band wide enough to see plenty of hits.
	task automatic program_random_camera();
		int lo;
		lo = -$urandom_range(0, 3000);
		program_camera($urandom_range(4000, 20000), $urandom_range(4000, 20000),
			$urandom_range(0, 16383), 16 * $urandom_range(100, 900) + $urandom_range(0, 15),
			lo, lo + $urandom_range(1, 4000), $urandom_range(0, 500));
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		int c;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Register defaults straight out of reset.
		push_pixel(65535, 0, 0, 1);      // far below the band: no hit, zeros out
		push_pixel(0, 1, 0, 1);          // no measurement never qualifies
		push_pixel(600, 1023, 0, 1);     // single-row frame in the top column
		push_pixel(50, 2, 0, 0);         // depth equal to the minimum range is rejected
		push_pixel(51, 2, 240, 1);       // one above it counts
		push_pixel(0, 3, 0, 0);
		push_pixel(10500, 3, 245, 1);    // height right on the upper edge: excluded
		push_pixel(0, 4, 0, 0);
		push_pixel(10499, 4, 245, 1);    // just under the upper edge
		push_pixel(0, 6, 0, 0);
		push_pixel(10500, 6, 225, 1);    // height right on the lower edge: included
		push_pixel(0, 0, 0, 0);
		push_pixel(60000, 0, 240, 1);    // lateral clips at the positive limit
		push_pixel(0, 1022, 0, 0);
		push_pixel(60000, 1022, 240, 1); // lateral clips at the negative limit
		push_pixel(600, 5, 0, 0);
		push_pixel(1000, 5, 240, 1);     // keeps the nearer row-0 depth
		push_pixel(0, 5, 0, 1);          // row 0 overwrites what the column held
		push_pixel(0, 320, 0, 0);
		push_pixel(700, 320, 240, 1);    // on the optical axis: hit with lateral 0
		push_pixel(900, 8, 0, 0);        // back-to-back updates of one column
		push_pixel(800, 8, 240, 0);
		push_pixel(850, 8, 240, 0);
		push_pixel(700, 8, 241, 1);
		push_random(25);
		settle();

		// Every register written; center_x of half a pixel makes exact halves.
		program_camera(8400, 4200, 8, 4000, -500, 500, 10);
		push_pixel(0, 0, 0, 0);
		push_pixel(525, 0, 250, 1);      // +0.5 mm rounds up to 1
		push_pixel(0, 1, 0, 0);
		push_pixel(525, 1, 250, 1);      // -0.5 mm rounds down to -1
		push_random(25);
		settle();

		// Extremes: widest band, no minimum, every nonzero depth qualifies.
		program_camera(16, 65535, 65535, 0, -32768, 32767, 0);
		push_random(22);
		settle();

		// Opposite extremes: minimum range at full scale, nothing qualifies.
		program_camera(65535, 16, 0, 65535, 32767, -32768, 65535);
		push_random(15);
		settle();

		// Zero horizontal focal length: lateral goes to the limit by sign.
		program_camera(0, 8400, 5120, 3840, -300, 100, 50);
		push_pixel(600, 320, 0, 1);      // zero offset stays 0
		push_pixel(600, 319, 0, 1);
		push_pixel(600, 321, 0, 1);
		push_random(22);
		settle();

		// Zero vertical focal length collapses both band edges to 0.
		program_camera(8400, 0, 5120, 3840, -300, 100, 50);
		push_random(15);
		settle();

		// Empty band.
		program_camera(8400, 8400, 5120, 3840, 100, -100, 50);
		push_random(15);
		settle();

		// Hold off the scan side while a long single-row frame streams in, so
		// the result buffer fills and the pixel side has to stall.
		program_random_camera();
		hold_off_req = 1'b1;
		for (c = 0; c < 96; c++)
			push_pixel(random_depth(), 100 + c, 0, 1);
		push_random(20);
		settle();

		// Pause the sender mid-phase until every scan request has come back.
		program_random_camera();
		push_random(15);
		wait_drained();
		push_random(15);
		settle();

		program_random_camera();
		push_random(25);
		settle();

		// Back to the reset values.
		program_camera(8400, 8400, 5120, 3840, -300, 100, 50);
		push_random(25);
		settle();

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
